// ===== rtl/core/rc4_stream_cipher_assert.svh =====
// Assertion macros for the RC4 stream cipher block.
// Included by the top level; no other dependencies.
`ifndef RC4_STREAM_CIPHER_ASSERT_SVH
`define RC4_STREAM_CIPHER_ASSERT_SVH

`ifndef SYNTHESIS
// Condition in this cycle implies consequence in the same cycle.
`define RC4_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rc4 assertion failed");
// Condition in this cycle implies consequence in the next cycle.
`define RC4_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rc4 assertion failed");
`else
`define RC4_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RC4_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/rc4_pkg.sv =====
// Shared types and constants for the RC4 stream cipher block.
// No dependencies.
package rc4_pkg;

    localparam int BOX_ENTRIES   = 256;
    localparam int BOX_AW        = 8;
    localparam int KEY_MAX_BYTES = 32;
    localparam int KEY_IDX_W     = 5;
    localparam int KEY_WORDS     = 4;
    localparam int KEY_LEN_W     = 6;
    localparam int CFG_ADDR_W    = 3;
    localparam int CFG_DATA_W    = 64;

    typedef logic [7:0] t_byte;

    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 6'd16;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_LENGTH = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_WORD0  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_WORD1  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_WORD2  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_WORD3  = 3'd4;

endpackage

// ===== rtl/core/rc4_stream_cipher.sv =====
// RC4 stream cipher top level: permutation box RAM, key schedule and generation sequencer.
// Depends on rc4_pkg and rc4_stream_cipher_assert.svh.
//
// Each input item carries one data byte (tdata) and a rekey flag (tuser); each item gives
// exactly one output byte, the data byte XORed with the next keystream byte. Without rekey
// an item runs through G2, G3 and G4 in turn: the reads of S[i], S[j] and S[S[i]+S[j]]
// depend on each other and go through the one registered read port of the 256x8 box RAM.
// With rekey the box returns to identity at once (per-entry valid bits) and the key schedule
// then runs one swap step per box entry, each through KS_RD, KS_J and KS_WR, before the byte
// itself is processed in G1 to G4. The output register lets the next item be taken while a
// result waits; a result held back by the sink stalls the block in its last step.
`include "rc4_stream_cipher_assert.svh"

module rc4_stream_cipher
    import rc4_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]            s_axis_tuser,   // [0] rekey
    // output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata    // [7:0] out_byte
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_KS_RD = 3'd1;
    localparam logic [2:0] ST_KS_J  = 3'd2;
    localparam logic [2:0] ST_KS_WR = 3'd3;
    localparam logic [2:0] ST_G1    = 3'd4;
    localparam logic [2:0] ST_G2    = 3'd5;
    localparam logic [2:0] ST_G3    = 3'd6;
    localparam logic [2:0] ST_G4    = 3'd7;

    // configuration
    logic [KEY_LEN_W-1:0]  r_key_length;
    logic [CFG_DATA_W-1:0] r_key_word [KEY_WORDS];

    // sequencer state
    logic [2:0]           r_state, n_state;
    t_byte                r_i, n_i;
    t_byte                r_j, n_j;
    logic [BOX_AW-1:0]    r_k, n_k;
    logic [KEY_IDX_W-1:0] r_kidx, n_kidx;
    t_byte                r_acc, n_acc;
    t_byte                r_sk, n_sk;
    t_byte                r_si, n_si;
    t_byte                r_sel, n_sel;
    t_byte                r_data, n_data;
    logic                 r_out_valid, n_out_valid;
    t_byte                r_out_data, n_out_data;

    // box RAM and its read side
    t_byte                r_mem [BOX_ENTRIES];
    logic [BOX_ENTRIES-1:0] r_valid;
    t_byte                r_q;
    logic [BOX_AW-1:0]    r_rd_addr;
    logic                 r_rd_valid;
    logic                 r_fwd_hit;
    t_byte                r_fwd_data;

    logic                 rd_en;
    logic [BOX_AW-1:0]    rd_addr;
    logic                 wr_en;
    logic [BOX_AW-1:0]    wr_addr;
    t_byte                wr_data;
    logic                 clear_valid;

    logic                 in_acc;
    logic                 out_free;
    t_byte                rd_val;
    t_byte                ks_byte;
    t_byte                key_byte;
    logic [KEY_IDX_W-1:0] len_m1;
    logic [KEY_MAX_BYTES*8-1:0] key_bits;

    assign key_bits = {r_key_word[3], r_key_word[2], r_key_word[1], r_key_word[0]};
    assign key_byte = key_bits[{r_kidx, 3'b000} +: 8];

    // Zero length acts as one byte, anything above the maximum saturates.
    always_comb begin
        if (r_key_length == '0) begin
            len_m1 = '0;
        end else if (r_key_length > KEY_LEN_W'(KEY_MAX_BYTES)) begin
            len_m1 = KEY_IDX_W'(KEY_MAX_BYTES - 1);
        end else begin
            len_m1 = KEY_IDX_W'(r_key_length - 6'd1);
        end
    end

    // An entry never written since the last identity fill reads as its own index; a read that
    // met a write to the same entry in its cycle takes the written byte.
    assign rd_val  = r_fwd_hit ? r_fwd_data : (r_rd_valid ? r_q : r_rd_addr);
    // S[j] is written only after the read of S[sel] was issued, so that case is forwarded here.
    assign ks_byte = (r_sel == r_j) ? r_si : rd_val;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) || ((r_state == ST_G4) && out_free);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_kidx      = r_kidx;
        n_acc       = r_acc;
        n_sk        = r_sk;
        n_si        = r_si;
        n_sel       = r_sel;
        n_data      = r_data;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        rd_en       = 1'b0;
        rd_addr     = r_i;
        wr_en       = 1'b0;
        wr_addr     = r_j;
        wr_data     = r_si;
        clear_valid = 1'b0;

        case (r_state)
            ST_IDLE: begin
            end
            ST_KS_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_k;
                // Second half of the previous swap step.
                wr_en   = (r_k != '0);
                wr_addr = r_acc;
                wr_data = r_sk;
                n_state = ST_KS_J;
            end
            ST_KS_J: begin
                n_sk    = rd_val;
                n_acc   = r_acc + rd_val + key_byte;
                rd_en   = 1'b1;
                rd_addr = n_acc;
                n_state = ST_KS_WR;
            end
            ST_KS_WR: begin
                wr_en   = 1'b1;
                wr_addr = r_k;
                wr_data = rd_val;
                n_k     = r_k + 8'd1;
                n_kidx  = (r_kidx == len_m1) ? '0 : r_kidx + 5'd1;
                n_state = (r_k == 8'hFF) ? ST_G1 : ST_KS_RD;
            end
            ST_G1: begin
                wr_en   = 1'b1;
                wr_addr = r_acc;
                wr_data = r_sk;
                n_i     = r_i + 8'd1;
                rd_en   = 1'b1;
                rd_addr = n_i;
                n_state = ST_G2;
            end
            ST_G2: begin
                n_si    = rd_val;
                n_j     = r_j + rd_val;
                rd_en   = 1'b1;
                rd_addr = n_j;
                n_state = ST_G3;
            end
            ST_G3: begin
                wr_en   = 1'b1;
                wr_addr = r_i;
                wr_data = rd_val;
                n_sel   = r_si + rd_val;
                rd_en   = 1'b1;
                rd_addr = n_sel;
                n_state = ST_G4;
            end
            ST_G4: begin
                wr_en   = 1'b1;
                wr_addr = r_j;
                wr_data = r_si;
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_data ^ ks_byte;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (in_acc) begin
            n_data = s_axis_tdata;
            if (s_axis_tuser[0]) begin
                clear_valid = 1'b1;
                n_i         = '0;
                n_j         = '0;
                n_k         = '0;
                n_kidx      = '0;
                n_acc       = '0;
                n_state     = ST_KS_RD;
            end else begin
                n_i     = r_i + 8'd1;
                rd_en   = 1'b1;
                rd_addr = n_i;
                n_state = ST_G2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_kidx      <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_i         <= n_i;
            r_j         <= n_j;
            r_k         <= n_k;
            r_kidx      <= n_kidx;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sk       <= n_sk;
        r_si       <= n_si;
        r_sel      <= n_sel;
        r_data     <= n_data;
        r_out_data <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_length  <= KEY_LEN_RESET;
            r_key_word[0] <= '0;
            r_key_word[1] <= '0;
            r_key_word[2] <= '0;
            r_key_word[3] <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_KEY_LENGTH: r_key_length  <= i_cfg_wdata[KEY_LEN_W-1:0];
                CFG_KEY_WORD0:  r_key_word[0] <= i_cfg_wdata;
                CFG_KEY_WORD1:  r_key_word[1] <= i_cfg_wdata;
                CFG_KEY_WORD2:  r_key_word[2] <= i_cfg_wdata;
                CFG_KEY_WORD3:  r_key_word[3] <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Box RAM: one write and one registered read per cycle, read-first.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_q        <= r_mem[rd_addr];
            r_rd_addr  <= rd_addr;
            r_rd_valid <= r_valid[rd_addr];
            r_fwd_hit  <= wr_en && (wr_addr == rd_addr);
            r_fwd_data <= wr_data;
        end
    end

    // Valid bits: clearing them all restores the identity permutation.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clear_valid) begin
            r_valid <= '0;
        end else if (wr_en) begin
            r_valid[wr_addr] <= 1'b1;
        end
    end

    `RC4_ASSERT_IMP(a_ready_states, i_clk, i_rst_n, s_axis_tready,
        (r_state == ST_IDLE) || (r_state == ST_G4))
    `RC4_ASSERT_NXT(a_rekey_starts_schedule, i_clk, i_rst_n, in_acc && s_axis_tuser[0],
        (r_state == ST_KS_RD) && (r_k == '0) && (r_valid == '0))
    `RC4_ASSERT_NXT(a_result_loaded, i_clk, i_rst_n, (r_state == ST_G4) && out_free,
        r_out_valid)
    `RC4_ASSERT_NXT(a_schedule_ends, i_clk, i_rst_n, (r_state == ST_KS_WR) && (r_k == 8'hFF),
        r_state == ST_G1)

endmodule

// ===== sim/rc4_stream_cipher_chk.sv =====
// Scoreboard for the RC4 stream cipher: watches the config port and both streams,
// keeps its own copy of the permutation box and indices, and checks every output item.
// Depends on rc4_pkg.
module rc4_stream_cipher_chk
    import rc4_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [7:0]            i_s_tdata,   // [7:0] data_byte
    input  logic [0:0]            i_s_tuser,   // [0] rekey
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [7:0]            i_m_tdata,   // [7:0] out_byte
    output int                    o_fail_count,
    output int                    o_pending
);

    t_byte                 perm [BOX_ENTRIES];
    t_byte                 idx_i;
    t_byte                 idx_j;
    logic [KEY_LEN_W-1:0]  key_len;
    logic [CFG_DATA_W-1:0] key_word [KEY_WORDS];
    t_byte                 expected_out_bytes [$];
    int                    fails = 0;

    function automatic void fill_identity();
        for (int k = 0; k < BOX_ENTRIES; k++)
            perm[k] = t_byte'(k);
    endfunction

    function automatic void run_key_schedule();
        int    len;
        int    n;
        t_byte acc;
        t_byte tmp;
        // A zero length acts as one byte; anything past the key size saturates.
        len = (key_len == 0) ? 1 : (key_len > KEY_MAX_BYTES) ? KEY_MAX_BYTES : int'(key_len);
        fill_identity();
        acc = '0;
        for (int k = 0; k < BOX_ENTRIES; k++) begin
            n       = k % len;
            acc     = acc + perm[k] + key_word[n / 8][(n % 8) * 8 +: 8];
            tmp     = perm[k];
            perm[k] = perm[acc];
            perm[acc] = tmp;
        end
        idx_i = '0;
        idx_j = '0;
    endfunction

    function automatic t_byte cipher_byte(t_byte data, logic rekey);
        t_byte tmp;
        t_byte sel;
        if (rekey)
            run_key_schedule();
        idx_i       = idx_i + 8'd1;
        idx_j       = idx_j + perm[idx_i];
        tmp         = perm[idx_i];
        perm[idx_i] = perm[idx_j];
        perm[idx_j] = tmp;
        sel         = perm[idx_i] + perm[idx_j];
        return data ^ perm[sel];
    endfunction

    always @(posedge i_clk) begin
        t_byte want;
        if (!i_rst_n) begin
            fill_identity();
            idx_i   = '0;
            idx_j   = '0;
            key_len = KEY_LEN_RESET;
            for (int w = 0; w < KEY_WORDS; w++)
                key_word[w] = '0;
            expected_out_bytes.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_KEY_LENGTH: key_len     = i_cfg_wdata[KEY_LEN_W-1:0];
                    CFG_KEY_WORD0:  key_word[0] = i_cfg_wdata;
                    CFG_KEY_WORD1:  key_word[1] = i_cfg_wdata;
                    CFG_KEY_WORD2:  key_word[2] = i_cfg_wdata;
                    CFG_KEY_WORD3:  key_word[3] = i_cfg_wdata;
                    default: ;
                endcase
            end
            // Results are retired before the new item is queued; an item accepted on
            // this edge cannot have produced its output yet.
            if (i_m_tvalid && i_m_tready) begin
                if (expected_out_bytes.size() == 0) begin
                    $display("%0t: unexpected out_byte, expected none, actual %02h",
                             $time, i_m_tdata);
                    fails++;
                end else begin
                    want = expected_out_bytes.pop_front();
                    if (i_m_tdata !== want) begin
                        $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                                 $time, want, i_m_tdata);
                        fails++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                expected_out_bytes.push_back(cipher_byte(i_s_tdata, i_s_tuser[0]));
        end
        o_fail_count <= fails;
        o_pending    <= expected_out_bytes.size();
    end

endmodule

// ===== sim/tb.sv =====
// Top of the RC4 stream cipher testbench: clock, reset, key setup and byte stimulus.
// Depends on rc4_pkg, rc4_stream_cipher and the scoreboard rc4_stream_cipher_chk.
module tb;
    import rc4_pkg::*;

    localparam int RANDOM_BYTES = 1500;
    localparam int IDLE_PCT     = 28;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = CFG_KEY_LENGTH;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;
    logic [0:0]            s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;
    logic                  idle_on       = 1'b1;
    int                    fail_count;
    int                    pending;

    rc4_stream_cipher uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    rc4_stream_cipher_chk chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // This bound is far above the slowest run, rekey items included.
    initial begin
        #10_000_000;
        $display("tb: FAIL");
        $finish;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
    end

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
    endtask

    task automatic cfg_done();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // The block is idle once the last output item is in and a short settle time has passed.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_key(input logic [KEY_LEN_W-1:0] len, input logic [CFG_DATA_W-1:0] w0,
                           input logic [CFG_DATA_W-1:0] w1, input logic [CFG_DATA_W-1:0] w2,
                           input logic [CFG_DATA_W-1:0] w3);
        wait_idle();
        cfg_write(CFG_KEY_LENGTH, CFG_DATA_W'(len));
        cfg_write(CFG_KEY_WORD0, w0);
        cfg_write(CFG_KEY_WORD1, w1);
        cfg_write(CFG_KEY_WORD2, w2);
        cfg_write(CFG_KEY_WORD3, w3);
        cfg_done();
    endtask

    task automatic send_item(input logic [7:0] data, input logic rekey);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid   <= 1'b1;
        s_axis_tdata    <= data;
        s_axis_tuser[0] <= rekey;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    initial begin
        int   sent;
        int   n;
        logic fresh;
        logic [KEY_LEN_W-1:0] len;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Nothing keyed yet: the stream comes from the identity box, then the reset key.
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'hA5, 1'b0);
        send_item(8'h3C, 1'b1);
        send_item(8'hC3, 1'b1);
        send_item(8'h5A, 1'b0);

        // Longest key with extreme word patterns.
        set_key(6'd32, '1, '0, rand_word(), rand_word());
        send_item(8'hFF, 1'b1);
        send_item(8'h00, 1'b0);
        send_item(8'h81, 1'b0);

        // Shortest key.
        set_key(6'd1, 64'h0000_0000_0000_00FF, '1, '1, '1);
        send_item(8'h00, 1'b1);
        send_item(8'h7E, 1'b0);

        // A zero length behaves like one byte, an oversized one like the full key.
        set_key(6'd0, rand_word(), rand_word(), rand_word(), rand_word());
        send_item(8'h12, 1'b1);
        send_item(8'hED, 1'b0);
        set_key(6'd63, rand_word(), rand_word(), rand_word(), rand_word());
        send_item(8'h34, 1'b1);
        send_item(8'hCB, 1'b0);

        // Writes past the last register must leave the key alone.
        wait_idle();
        for (int a = int'(CFG_KEY_WORD3) + 1; a < (1 << CFG_ADDR_W); a++)
            cfg_write(CFG_ADDR_W'(a), '1);
        cfg_done();
        send_item(8'h56, 1'b1);
        send_item(8'hA9, 1'b0);

        // Random messages: mostly a fresh key and rekey at the head, random payload after.
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            fresh = ($urandom_range(3) != 0);
            if (fresh) begin
                case ($urandom_range(9))
                    0:       len = 6'd1;
                    1:       len = 6'd32;
                    default: len = KEY_LEN_W'($urandom_range(1, KEY_MAX_BYTES));
                endcase
                set_key(len, rand_word(), rand_word(), rand_word(), rand_word());
            end
            idle_on <= !(sent >= 500 && sent < 800);
            n = $urandom_range(4, 40);
            for (int k = 0; k < n; k++)
                send_item(8'($urandom_range(255)),
                          (k == 0 && (fresh || $urandom_range(1) == 1))
                          || ($urandom_range(63) == 0));
            sent += n;
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
